// ===== src/ccc_pkg.sv =====
// Shared types, constants and the CRC step function of the config stream CRC checker.
package ccc_pkg;

  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 16;
  localparam int CRC_W      = 32;
  localparam int FEED_W     = DATA_W + ADDR_W;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 32'h1EDC_6F41;
  localparam logic [ADDR_W-1:0] CMD_ADDRESS   = 6'd5;
  localparam logic [ADDR_W-1:0] CHECK_ADDRESS = 6'd0;
  localparam logic [DATA_W-1:0] CMD_RESET_CRC = 16'd7;

  // Check kinds on the result channel
  localparam logic KIND_EXPLICIT = 1'b0;
  localparam logic KIND_AUTO     = 1'b1;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_CHECK,
    OP_FEED
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [FEED_W-1:0] feed_bits;   // {address, data}, fed from bit 0 upward
    logic              emit_auto;   // feed then report and clear
    logic [CRC_W-1:0]  expected;
  } op_entry_t;

  // Result item
  typedef struct packed {
    logic             check_kind;
    logic [CRC_W-1:0] calculated_crc;
    logic [CRC_W-1:0] expected_crc;
    logic             crc_match;
  } result_t;

  // Non-reflected CRC-32C over FEED_W bits, least significant bit first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [FEED_W-1:0] bits);
    logic [CRC_W-1:0] c;
    logic             top;
    c = crc;
    for (int i = 0; i < FEED_W; i++) begin
      top = c[CRC_W-1] ^ bits[i];
      c   = {c[CRC_W-2:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/ccc_in_if.sv =====
// Input and result channel interfaces of the config stream CRC checker.
interface ccc_in_if import ccc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_write;
  logic [ADDR_W-1:0] reg_address;
  logic [DATA_W-1:0] data_word;
  logic              first_word;
  logic              last_word;
  logic              type_two;

  modport source (output valid, is_write, reg_address, data_word, first_word,
                  last_word, type_two, input ready);
  modport sink (input valid, is_write, reg_address, data_word, first_word,
                last_word, type_two, output ready);
endinterface

interface ccc_out_if import ccc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             check_kind;
  logic [CRC_W-1:0] calculated_crc;
  logic [CRC_W-1:0] expected_crc;
  logic             crc_match;

  modport source (output valid, check_kind, calculated_crc, expected_crc, crc_match,
                  input ready);
  modport sink (input valid, check_kind, calculated_crc, expected_crc, crc_match,
                output ready);
endinterface

// ===== src/ccc_front.sv =====
// Front end: accepts write words, tracks packet skipping and expected-value capture.
module ccc_front import ccc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ccc_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       q_push,
  output op_entry_t  q_entry
);

  localparam logic [1:0] POS_NONE = 2'd0;
  localparam logic [1:0] POS_HIGH = 2'd1;
  localparam logic [1:0] POS_BOTH = 2'd2;

  logic              skip_r, skip_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [DATA_W-1:0] exp_hi_r, exp_hi_nxt;
  logic [DATA_W-1:0] exp_lo_r, exp_lo_nxt;
  logic              accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Classify the request
  always_comb begin
    skip_nxt   = skip_r;
    pos_nxt    = pos_r;
    exp_hi_nxt = exp_hi_r;
    exp_lo_nxt = exp_lo_r;
    q_push     = 1'b0;
    q_entry.kind      = OP_FEED;
    q_entry.feed_bits = {in_ch.reg_address, in_ch.data_word};
    q_entry.emit_auto = in_ch.last_word && in_ch.type_two;
    q_entry.expected  = '0;

    if (accept && in_ch.is_write) begin
      if (in_ch.first_word) begin
        skip_nxt = 1'b0;
      end
      if (skip_r && !in_ch.first_word) begin
        // inside a skipped packet
        if (in_ch.last_word) begin
          skip_nxt = 1'b0;
        end
      end else if (in_ch.first_word && in_ch.reg_address == CMD_ADDRESS &&
                   in_ch.data_word == CMD_RESET_CRC) begin
        q_push       = 1'b1;
        q_entry.kind = OP_CLEAR;
        skip_nxt     = !in_ch.last_word;
      end else if (in_ch.reg_address == CHECK_ADDRESS) begin
        if (in_ch.first_word || pos_r == POS_NONE) begin
          exp_hi_nxt = in_ch.data_word;
          exp_lo_nxt = '0;
          pos_nxt    = POS_HIGH;
        end else if (pos_r == POS_HIGH) begin
          exp_lo_nxt = in_ch.data_word;
          pos_nxt    = POS_BOTH;
        end
        if (in_ch.last_word) begin
          q_push           = 1'b1;
          q_entry.kind     = OP_CHECK;
          q_entry.expected = {exp_hi_nxt, exp_lo_nxt};
          pos_nxt          = POS_NONE;
        end
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r   <= 1'b0;
      pos_r    <= POS_NONE;
      exp_hi_r <= '0;
      exp_lo_r <= '0;
    end else begin
      skip_r   <= skip_nxt;
      pos_r    <= pos_nxt;
      exp_hi_r <= exp_hi_nxt;
      exp_lo_r <= exp_lo_nxt;
    end
  end

endmodule

// ===== src/ccc_fifo.sv =====
// Short queue of classified operations between the front and the back.
module ccc_fifo import ccc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  op_entry_t push_entry,
  input  logic      pop,
  output op_entry_t head,
  output logic      empty,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_entry_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == FULL_CNT);
  assign head  = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/ccc_back.sv =====
// Back end: runs the CRC and drives the registered result channel.
module ccc_back import ccc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  op_entry_t head,
  input  logic      q_empty,
  output logic      q_pop,
  ccc_out_if.source out_ch
);

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;
  logic [CRC_W-1:0] fed;
  logic             emits;

  assign fed   = crc_feed(crc_r, head.feed_bits);
  assign emits = (head.kind == OP_CHECK) || (head.kind == OP_FEED && head.emit_auto);
  assign q_pop = !q_empty && (!emits || !out_valid_r || out_ch.ready);

  // Execute the head operation
  always_comb begin
    crc_nxt       = crc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (q_pop) begin
      case (head.kind)
        OP_CLEAR: begin
          crc_nxt = '0;
        end
        OP_CHECK: begin
          out_nxt.check_kind     = KIND_EXPLICIT;
          out_nxt.calculated_crc = crc_r;
          out_nxt.expected_crc   = head.expected;
          out_nxt.crc_match      = (crc_r == head.expected);
          out_valid_nxt          = 1'b1;
          crc_nxt                = '0;
        end
        OP_FEED: begin
          if (head.emit_auto) begin
            out_nxt.check_kind     = KIND_AUTO;
            out_nxt.calculated_crc = fed;
            out_nxt.expected_crc   = '0;
            out_nxt.crc_match      = 1'b0;
            out_valid_nxt          = 1'b1;
            crc_nxt                = '0;
          end else begin
            crc_nxt = fed;
          end
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.check_kind     = out_r.check_kind;
  assign out_ch.calculated_crc = out_r.calculated_crc;
  assign out_ch.expected_crc   = out_r.expected_crc;
  assign out_ch.crc_match      = out_r.crc_match;

endmodule

// ===== src/config_stream_crc_checker.sv =====
// Top level of the configuration write stream CRC-32C checker.
//
// in_ch carries one word of a configuration packet per request: write flag,
// register address, 16-bit data and first/last/type-2 markers. out_ch
// carries check results: kind, calculated CRC, expected CRC and match flag.
// Both channels use valid/ready; a request moves when both are high.
//
// The front end classifies each word in the cycle it is taken and queues a
// clear, feed or check operation; the back end runs a 22-bit parallel
// CRC-32C update per operation and loads a single output register.
// Throughput is one word per cycle while the queue is not full. A result
// becomes valid once the word that caused it has passed through the queue
// entry and then the output register.
//
// If the receiver stalls, the result waits in the output register while
// non-reporting words keep flowing; once the queue of QUEUE_DEPTH entries
// fills, in_ch.ready drops. Reset clears the CRC, the skip and capture
// state, the queue and the valid flag of the output register.
module config_stream_crc_checker import ccc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  ccc_in_if.sink    in_ch,
  ccc_out_if.source out_ch
);

  logic      q_push, q_pop, q_empty, q_full;
  op_entry_t q_entry, q_head;

  ccc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  ccc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  ccc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
